// ----- src/bae_pkg.sv -----
// ----------------------------------------------------------------------------
// bae_pkg
// Shared constants and helpers for the binary arithmetic encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bae_pkg;

    localparam int BOUND_W     = 32;
    localparam int PROB_W      = 16;
    localparam int BITS_W      = 5;
    localparam int BYTE_W      = 8;
    localparam int IN_DATA_W   = 24;

    localparam logic [BITS_W-1:0]  PROB_BITS_RESET = 5'd12;
    localparam logic [BITS_W-1:0]  PROB_BITS_MIN   = 5'd1;
    localparam logic [BITS_W-1:0]  PROB_BITS_MAX   = 5'd16;
    localparam logic [BOUND_W-1:0] BOUND_ONES      = 32'hFFFF_FFFF;
    localparam logic [BOUND_W-1:0] BOUND_ZERO      = 32'h0000_0000;
    localparam logic [BYTE_W-1:0]  BYTE_ONES       = 8'hFF;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    // Precision as used: zero reads as one, above sixteen reads as sixteen.
    function automatic logic [BITS_W-1:0] eff_bits(input logic [BITS_W-1:0] bits);
        logic [BITS_W-1:0] res;
        res = bits;
        if (bits < PROB_BITS_MIN)
        begin
            res = PROB_BITS_MIN;
        end
        else if (bits > PROB_BITS_MAX)
        begin
            res = PROB_BITS_MAX;
        end
        return res;
    endfunction

    // Largest probability code for the given precision.
    function automatic logic [PROB_W-1:0] prob_max(input logic [BITS_W-1:0] bits);
        logic [PROB_W:0] full;
        full = (17'd1 << eff_bits(bits)) - 17'd1;
        return full[PROB_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/binary_arithmetic_encoder.sv -----
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder
// Carryless 32-bit binary arithmetic encoder with byte-wise renormalization.
//
// Channel   Dir  Signals                      Payload
// s_axis    in   tvalid tready tdata tuser    tdata: prob_zero, bit_value; tuser: mode
// m_axis    out  tvalid tready tdata tlast    tdata: out_byte; tlast: last_of_run
// cfg       in   cfg_wr_en cfg_wr_data        prob_bits
//
// Encode item: accept, multiply, interval update, then renormalization, which emits
// a byte per step while the bounds' top bytes agree, four at most; one 32x16
// multiplier and a single renormalization shifter. Flush: lower_reg bytes, top first.
// A stalled m_axis holds the sequencer on the pending byte.
// Reset (rst_n low, asynchronous): bounds to all ones / zero, prob_bits to 12.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_arithmetic_encoder
    import bae_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,  // [15:0] prob_zero, [16] bit_value
    input  wire logic                 s_axis_tuser,  // [0] mode
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [BYTE_W-1:0]         m_axis_tdata,  // [7:0] out_byte
    output logic                      m_axis_tlast,
    input  wire logic                 cfg_wr_en,
    input  wire logic [BITS_W-1:0]    cfg_wr_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPDATE,
        ST_RENORM,
        ST_FLUSH
    } state_t;

    state_t               state_reg;
    logic [BITS_W-1:0]    prob_bits_reg;
    logic [BOUND_W-1:0]   upper_reg;
    logic [BOUND_W-1:0]   lower_reg;
    logic [BOUND_W-1:0]   prod_reg;
    logic [PROB_W-1:0]    prob_reg;
    logic                 bit_reg;
    logic [1:0]           count_reg;
    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic                 out_last_reg;

    logic                 accept;
    logic                 out_free;
    logic                 emit;
    logic [PROB_W-1:0]    prob_in;
    logic [PROB_W-1:0]    pmax;
    logic [BOUND_W-1:0]   width_shr;
    logic [BOUND_W+PROB_W-1:0] prod_next;
    logic [BOUND_W-1:0]   split_next;
    logic                 top_eq;
    logic                 next_eq;
    logic [BYTE_W-1:0]    flush_byte;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign emit          = out_free && (((state_reg == ST_RENORM) && top_eq) ||
                                        (state_reg == ST_FLUSH));

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

    assign pmax       = prob_max(prob_bits_reg);
    assign prob_in    = (s_axis_tdata[PROB_W-1:0] > pmax) ? pmax : s_axis_tdata[PROB_W-1:0];
    assign width_shr  = (upper_reg - lower_reg) >> eff_bits(prob_bits_reg);
    assign prod_next  = width_shr * prob_reg;
    assign split_next = lower_reg + prod_reg;
    assign top_eq     = (upper_reg[31:24] == lower_reg[31:24]);
    assign next_eq    = (upper_reg[23:16] == lower_reg[23:16]);

    always_comb
    begin
        case (count_reg)
            2'd0:    flush_byte = lower_reg[31:24];
            2'd1:    flush_byte = lower_reg[23:16];
            2'd2:    flush_byte = lower_reg[15:8];
            default: flush_byte = lower_reg[7:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prob_bits_reg <= PROB_BITS_RESET;
            upper_reg     <= BOUND_ONES;
            lower_reg     <= BOUND_ZERO;
            count_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                prob_bits_reg <= cfg_wr_data;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        prob_reg  <= prob_in;
                        bit_reg   <= s_axis_tdata[PROB_W];
                        count_reg <= 2'd0;
                        state_reg <= (s_axis_tuser == MODE_FLUSH) ? ST_FLUSH : ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= prod_next[BOUND_W-1:0];
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    if (bit_reg)
                    begin
                        lower_reg <= split_next + 32'd1;
                    end
                    else
                    begin
                        upper_reg <= split_next;
                    end
                    state_reg <= ST_RENORM;
                end
                ST_RENORM:
                begin
                    if (!top_eq)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_byte_reg  <= upper_reg[31:24];
                        out_last_reg  <= !next_eq || (count_reg == 2'd3);
                        upper_reg     <= {upper_reg[23:0], BYTE_ONES};
                        lower_reg     <= {lower_reg[23:0], 8'h00};
                        count_reg     <= count_reg + 2'd1;
                        if (!next_eq || (count_reg == 2'd3))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (out_free)
                    begin
                        out_byte_reg  <= flush_byte;
                        out_last_reg  <= (count_reg == 2'd3);
                        count_reg     <= count_reg + 2'd1;
                        if (count_reg == 2'd3)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_flush_keeps_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |=> ($stable(upper_reg) && $stable(lower_reg)))
        else $error("bounds changed during flush");

    a_prob_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (prob_reg <= pmax))
        else $error("probability above precision limit");

    a_renorm_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RENORM && top_eq && out_free) |=> m_axis_tvalid)
        else $error("renormalization byte not presented");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("item accepted while previous still in work");
`endif

endmodule

`default_nettype wire
